### design/ckrh_pkg.sv
// ----------------------------------------------------------------------------
// ckrh_pkg
// Shared widths, register indexes and the controller command bundle for the
// canonical k-mer rolling hash block.
// ----------------------------------------------------------------------------
package ckrh_pkg;

  localparam int NUC_W      = 8;
  localparam int KMER_W     = 32;
  localparam int KLEN_W     = 5;
  localparam int TLOG_W     = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_KMER_LENGTH     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_SIZE_LOG2 = 2'd1;

  // One-hot style commands from the controller to the datapath.
  typedef struct packed {
    logic take_base;  // Shift the accepted base into both k-mers.
    logic pick_min;   // Load the smaller k-mer into the hash register.
    logic mix_a;      // First xor-shift and multiply round.
    logic mix_b;      // Second xor-shift and multiply round.
    logic load_out;   // Final xor-shift, mask, and load the output register.
  } ckrh_cmd_t;

endpackage

### design/ckrh_ctrl.sv
// ----------------------------------------------------------------------------
// ckrh_ctrl
// Sequencer for one base at a time: accept, pick the smaller k-mer, two
// hash rounds, then hand the result to the output register.
// ----------------------------------------------------------------------------
module ckrh_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  output ckrh_pkg::ckrh_cmd_t cmd
);
  import ckrh_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MIN  = 3'd1;
  localparam logic [2:0] ST_MA   = 3'd2;
  localparam logic [2:0] ST_MB   = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.take_base = 1'b1;
          state_nxt     = ST_MIN;
        end
      end
      ST_MIN: begin
        cmd.pick_min = 1'b1;
        state_nxt    = ST_MA;
      end
      ST_MA: begin
        cmd.mix_a = 1'b1;
        state_nxt = ST_MB;
      end
      ST_MB: begin
        cmd.mix_b = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        if (slot_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### design/ckrh_datapath.sv
// ----------------------------------------------------------------------------
// ckrh_datapath
// Configuration registers, rolling forward and reverse-complement k-mers,
// the fill counter, the shared hash register and the output register.
// ----------------------------------------------------------------------------
module ckrh_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  ckrh_pkg::ckrh_cmd_t                 cmd,
  input  logic                                cfg_we,
  input  logic [ckrh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ckrh_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic [ckrh_pkg::NUC_W-1:0]          in_nucleotide,
  input  logic                                in_restart,
  output logic [ckrh_pkg::KMER_W-1:0]         out_forward_kmer,
  output logic [ckrh_pkg::KMER_W-1:0]         out_reverse_kmer,
  output logic [ckrh_pkg::KMER_W-1:0]         out_bucket_index,
  output logic                                out_kmer_full
);
  import ckrh_pkg::*;

  localparam logic [KMER_W-1:0] MUL_A = 32'h2c1b3c6d;
  localparam logic [KMER_W-1:0] MUL_B = 32'h297a2d39;

  function automatic logic [1:0] fwd_code(input logic [NUC_W-1:0] ch);
    logic [1:0] c;
    case (ch)
      "C", "c": c = 2'd1;
      "G", "g": c = 2'd2;
      "T", "t": c = 2'd3;
      default:  c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic [1:0] comp_code(input logic [NUC_W-1:0] ch);
    logic [1:0] c;
    case (ch)
      "A":     c = 2'd3;
      "C":     c = 2'd2;
      "G":     c = 2'd1;
      default: c = 2'd0;
    endcase
    return c;
  endfunction

  function automatic logic [KMER_W-1:0] xshift(input logic [KMER_W-1:0] v);
    return v ^ (v >> 16);
  endfunction

  logic [KLEN_W-1:0] klen_r;
  logic [TLOG_W-1:0] tlog_r;
  logic [KMER_W-1:0] fwd_r, fwd_nxt;
  logic [KMER_W-1:0] rev_r, rev_nxt;
  logic [KLEN_W-1:0] fill_r, fill_nxt;
  logic              full_r;
  logic [KMER_W-1:0] hash_r;
  logic [KMER_W-1:0] fwd_o_r, rev_o_r, bkt_o_r;
  logic              full_o_r;

  logic [KLEN_W-1:0] k_eff;
  logic [KMER_W-1:0] kmask;
  logic [KMER_W-1:0] fwd_base, rev_base;
  logic [KLEN_W-1:0] fill_base;
  logic [KMER_W-1:0] comp_sh;
  logic [TLOG_W-1:0] lg;
  logic [KMER_W:0]   tmask_w;
  logic [KMER_W-1:0] tmask;

  // Length zero acts as one; anything above sixteen acts as sixteen.
  always_comb begin
    k_eff = klen_r;
    if (klen_r == '0) begin
      k_eff = KLEN_W'(1);
    end else if (klen_r > KLEN_W'(16)) begin
      k_eff = KLEN_W'(16);
    end
  end

  assign kmask = (k_eff == KLEN_W'(16)) ? '1
               : ((KMER_W'(1) << {k_eff, 1'b0}) - KMER_W'(1));

  assign fwd_base  = in_restart ? '0 : fwd_r;
  assign rev_base  = in_restart ? '0 : rev_r;
  assign fill_base = in_restart ? '0 : fill_r;
  assign comp_sh   = KMER_W'(comp_code(in_nucleotide)) << {k_eff - KLEN_W'(1), 1'b0};
  assign fwd_nxt   = ((fwd_base << 2) | KMER_W'(fwd_code(in_nucleotide))) & kmask;
  assign rev_nxt   = (rev_base >> 2) + comp_sh;
  assign fill_nxt  = (fill_base < KLEN_W'(16)) ? fill_base + KLEN_W'(1) : fill_base;

  assign lg      = (tlog_r > TLOG_W'(32)) ? TLOG_W'(32) : tlog_r;
  assign tmask_w = ((KMER_W+1)'(1) << lg) - (KMER_W+1)'(1);
  assign tmask   = tmask_w[KMER_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      klen_r <= KLEN_W'(16);
      tlog_r <= TLOG_W'(20);
      fwd_r  <= '0;
      rev_r  <= '0;
      fill_r <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_KMER_LENGTH) begin
        klen_r <= cfg_data[KLEN_W-1:0];
      end
      if (cfg_we && cfg_index == REG_TABLE_SIZE_LOG2) begin
        tlog_r <= cfg_data;
      end
      if (cmd.take_base) begin
        fwd_r  <= fwd_nxt;
        rev_r  <= rev_nxt;
        fill_r <= fill_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_base) begin
      full_r <= (fill_nxt >= k_eff);
    end
    if (cmd.pick_min) begin
      hash_r <= (fwd_r < rev_r) ? fwd_r : rev_r;
    end else if (cmd.mix_a) begin
      hash_r <= xshift(hash_r) * MUL_A;
    end else if (cmd.mix_b) begin
      hash_r <= xshift(hash_r) * MUL_B;
    end
    if (cmd.load_out) begin
      fwd_o_r  <= fwd_r;
      rev_o_r  <= rev_r;
      bkt_o_r  <= xshift(hash_r) & tmask;
      full_o_r <= full_r;
    end
  end

  assign out_forward_kmer = fwd_o_r;
  assign out_reverse_kmer = rev_o_r;
  assign out_bucket_index = bkt_o_r;
  assign out_kmer_full    = full_o_r;

endmodule

### design/canonical_kmer_rolling_hash_top.sv
// ----------------------------------------------------------------------------
// canonical_kmer_rolling_hash_top
// Canonical 2-bit k-mer rolling hash over a stream of nucleotide characters.
// ----------------------------------------------------------------------------
// Usage:
// The input channel carries one ASCII base per transfer, plus a restart bit
// that clears both k-mers and the fill count before that base is taken.
// Every input transfer yields exactly one output transfer carrying the
// forward k-mer, the reverse-complement k-mer, the masked hash of the smaller
// of the two, and a flag that is set once a full k-mer has been seen.
// The block handles one base at a time: the base is taken, then the
// controller walks the shared hash register through a min-select and two
// xor-shift-multiply rounds, one multiplier per cycle, and loads the output
// register. The next base is accepted only once the output register has
// been loaded, and the result shows on the output from that register.
// The output register holds one finished result; while the receiver stalls,
// the result and out_valid stay put and the block holds its last step until
// the register can take the next result. in_stall is high while a base is
// in flight.
// Reset (synchronous, active low) clears both k-mers, the fill count and
// out_valid, and restores kmer_length to 16 and table_size_log2 to 20.
// Configuration writes take effect on the next clock and belong to idle time.
// ----------------------------------------------------------------------------
module canonical_kmer_rolling_hash_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [ckrh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ckrh_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [ckrh_pkg::NUC_W-1:0]          in_nucleotide,
  input  logic                                in_restart,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ckrh_pkg::KMER_W-1:0]         out_forward_kmer,
  output logic [ckrh_pkg::KMER_W-1:0]         out_reverse_kmer,
  output logic [ckrh_pkg::KMER_W-1:0]         out_bucket_index,
  output logic                                out_kmer_full
);
  import ckrh_pkg::*;

  // Commands from the sequencer; the datapath reports no status back since
  // the sequencer's steps depend only on in_valid and out_stall.
  ckrh_cmd_t cmd;

  ckrh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ckrh_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_nucleotide    (in_nucleotide),
    .in_restart       (in_restart),
    .out_forward_kmer (out_forward_kmer),
    .out_reverse_kmer (out_reverse_kmer),
    .out_bucket_index (out_bucket_index),
    .out_kmer_full    (out_kmer_full)
  );

endmodule

### design/ckrh_checker.sv
// ----------------------------------------------------------------------------
// ckrh_checker
// Port-level checks for the canonical k-mer rolling hash block.
// ----------------------------------------------------------------------------
module ckrh_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic [ckrh_pkg::KMER_W-1:0]         out_forward_kmer,
  input logic [ckrh_pkg::KMER_W-1:0]         out_reverse_kmer,
  input logic [ckrh_pkg::KMER_W-1:0]         out_bucket_index,
  input logic                                out_kmer_full
);

  // A stalled result keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_forward_kmer)
      && $stable(out_reverse_kmer) && $stable(out_bucket_index)
      && $stable(out_kmer_full))
    else $error("stalled output changed");

  // Reset leaves no result pending.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // Only one base is in flight: a transfer closes the input side next cycle.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted while a base was in flight");

  // The hash runs through the min-select, both rounds and the output load, so no result appears right after a transfer.
  a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> !$rose(out_valid))
    else $error("result appeared too early");

endmodule

bind canonical_kmer_rolling_hash_top ckrh_checker u_ckrh_checker (.*);
